// ----- design/rpip_pkg.sv -----
// Package for the radix-prefixed integer parser.
// Holds the value width, the queue geometry, the ASCII and radix codes, the queue entry type and a digit decoder.
// No dependencies.
`timescale 1ns / 1ps

package rpip_pkg;

  // Width of the parsed value; digits wrap modulo 2^ValueBits
  localparam int unsigned ValueBits = 32;

  // Queue between the front and the back
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrBits   = $clog2(QDepth);
  localparam int unsigned QCountBits = $clog2(QDepth + 1);

  // ASCII codes the front looks for
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChHex   = 8'h24;  // '$'
  localparam logic [7:0] ChBin   = 8'h25;  // '%'
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChCase  = 8'h20;  // case-fold bit

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } radix_e;

  typedef enum logic {
    OP_DIGIT = 1'b0,  // fold one digit into the accumulator
    OP_EMIT  = 1'b1   // string ended: deliver the result, clear the accumulator
  } op_e;

  typedef struct packed {
    op_e        op;
    radix_e     radix;
    logic [3:0] digit;
    logic       neg;
    logic       err;
  } q_entry_t;

  typedef struct packed {
    logic       good;
    logic [3:0] digit;
  } digit_t;

  // Decode one character as a digit of the given radix
  function automatic digit_t decode_digit(logic [7:0] ch, radix_e radix);
    digit_t     res;
    logic [7:0] folded;
    logic [7:0] off;
    res    = '0;
    folded = ch | ChCase;
    off    = ch - ChZero;
    unique case (radix)
      RX_HEX: begin
        if (ch >= ChZero && ch <= ChNine) begin
          res.good  = 1'b1;
          res.digit = off[3:0];
        end else if (folded >= ChLowA && folded <= ChLowF) begin
          res.good  = 1'b1;
          res.digit = 4'(folded - ChLowA) + 4'd10;
        end
      end
      RX_BIN: begin
        res.good  = (ch == ChZero) || (ch == ChOne);
        res.digit = {3'b000, ch[0]};
      end
      default: begin
        res.good  = (ch >= ChZero && ch <= ChNine);
        res.digit = off[3:0];
      end
    endcase
    if (!res.good) begin
      res.digit = '0;
    end
    return res;
  endfunction

endpackage

// ----- design/rpip_front.sv -----
// Front of the parser: accepts characters and tracks blanks, sign, prefix and errors.
// Pushes digit and end-of-string operations into the queue. Depends on rpip_pkg.
`timescale 1ns / 1ps

module rpip_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        character_i,
  input  logic              q_full_i,
  output logic              push_o,
  output rpip_pkg::q_entry_t entry_o
);
  import rpip_pkg::*;

  typedef enum logic [1:0] {
    PH_BLANKS = 2'd0,
    PH_SIGNED = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  phase_e phase_q, phase_d;
  radix_e radix_q, radix_d;
  logic   neg_q, neg_d;
  logic   err_q, err_d;
  logic   accept;
  digit_t dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the character against the parse state
  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    err_d   = err_q;
    push_o  = 1'b0;
    entry_o = '{op: OP_DIGIT, radix: radix_q, digit: 4'd0, neg: neg_q, err: err_q};
    dec     = decode_digit(character_i, radix_q);

    if (accept) begin
      if (character_i == ChNul) begin
        // terminator: hand over sign and error, start over
        push_o     = 1'b1;
        entry_o.op = OP_EMIT;
        phase_d    = PH_BLANKS;
        radix_d    = RX_DEC;
        neg_d      = 1'b0;
        err_d      = 1'b0;
      end else begin
        priority if (phase_q == PH_BLANKS &&
                     (character_i == ChSpace || character_i == ChTab)) begin
          // leading blank, dropped
        end else if (phase_q == PH_BLANKS && character_i == ChMinus) begin
          neg_d   = 1'b1;
          phase_d = PH_SIGNED;
        end else if (phase_q != PH_DIGITS && character_i == ChHex) begin
          radix_d = RX_HEX;
          phase_d = PH_DIGITS;
        end else if (phase_q != PH_DIGITS && character_i == ChBin) begin
          radix_d = RX_BIN;
          phase_d = PH_DIGITS;
        end else begin
          // digit position; no prefix seen means decimal
          if (phase_q != PH_DIGITS) begin
            radix_d = RX_DEC;
            dec     = decode_digit(character_i, RX_DEC);
          end
          phase_d = PH_DIGITS;
          if (dec.good) begin
            push_o        = 1'b1;
            entry_o.radix = radix_d;
            entry_o.digit = dec.digit;
          end else begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BLANKS;
      radix_q <= RX_DEC;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- design/rpip_fifo.sv -----
// Short queue of operations between the front and the back of the parser.
// Register-based ring buffer read at its head. Depends on rpip_pkg.
`timescale 1ns / 1ps

module rpip_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  rpip_pkg::q_entry_t            entry_i,
  input  logic                          pop_i,
  output rpip_pkg::q_entry_t            head_o,
  output logic                          empty_o,
  output logic                          full_o,
  output logic [rpip_pkg::QCountBits-1:0] count_o
);
  import rpip_pkg::*;

  q_entry_t               mem_q [QDepth];
  logic [QPtrBits-1:0]    wptr_q, rptr_q;
  logic [QCountBits-1:0]  count_q;
  logic                   do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCountBits'(QDepth));
  assign count_o = count_q;
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + QPtrBits'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QPtrBits'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCountBits'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCountBits'(1);
      end
    end
  end

endmodule

// ----- design/rpip_back.sv -----
// Back of the parser: accumulates digits and delivers the result on end of string.
// Holds the accumulator and the output register. Depends on rpip_pkg.
`timescale 1ns / 1ps

module rpip_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rpip_pkg::q_entry_t                  head_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rpip_pkg::ValueBits-1:0] value_o,
  output logic                                ok_o
);
  import rpip_pkg::*;

  logic [ValueBits-1:0] acc_q, acc_d;
  logic [ValueBits-1:0] value_q, result;
  logic                 ok_q;
  logic                 valid_q;
  logic                 slot_free;
  logic [ValueBits-1:0] digit_ext;

  // A digit never waits; a result waits for a free output slot
  assign slot_free = !valid_q || out_ready_i;
  assign pop_o     = !empty_i && (head_i.op == OP_DIGIT || slot_free);
  assign digit_ext = ValueBits'(head_i.digit);

  // Multiply-add by the radix as shifts and adds
  always_comb begin
    unique case (head_i.radix)
      RX_HEX:  acc_d = (acc_q << 4) | digit_ext;
      RX_BIN:  acc_d = (acc_q << 1) | digit_ext;
      default: acc_d = (acc_q << 3) + (acc_q << 1) + digit_ext;
    endcase
  end

  // Signed result, forced to zero on a syntax error
  always_comb begin
    result = head_i.neg ? (ValueBits'(0) - acc_q) : acc_q;
    if (head_i.err) begin
      result = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o && head_i.op == OP_EMIT) begin
        acc_q   <= '0;
        valid_q <= 1'b1;
      end else begin
        if (pop_o) begin
          acc_q <= acc_d;
        end
        if (out_ready_i) begin
          valid_q <= 1'b0;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.op == OP_EMIT) begin
      value_q <= result;
      ok_q    <= !head_i.err;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign ok_o        = ok_q;

endmodule

// ----- design/radix_prefixed_integer_parser_unit.sv -----
// Top level of the radix-prefixed integer parser.
// Instantiates rpip_front, rpip_fifo and rpip_back. Depends on rpip_pkg.
//
// Takes one ASCII character per cycle on the input channel; a 0 byte ends the
// string and produces one result (value, ok) on the output channel. Leading
// blanks are skipped, a '-' negates, '$' selects hex and '%' binary, otherwise
// decimal; digits wrap modulo 2^32, and any bad character yields value 0 with
// ok low. The front classifies a character in the cycle it is accepted and
// the back folds one digit per cycle, so throughput is one character per
// cycle; a 4-entry operation queue between them absorbs output stalls, and the
// input stalls only once that queue is full. A terminator passes through the
// operation queue and then the output register before its result is presented.
`timescale 1ns / 1ps

module radix_prefixed_integer_parser_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          character_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rpip_pkg::ValueBits-1:0] value_o,
  output logic                                ok_o
);
  import rpip_pkg::*;

  q_entry_t              push_entry, head;
  logic                  push, pop, q_empty, q_full;
  logic [QCountBits-1:0] q_count;

  rpip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .character_i(character_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  rpip_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_count)
  );

  rpip_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .ok_o       (ok_o)
  );

  // A rejected string always reports zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (value_o == '0))
    else $error("error result with nonzero value");

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full queue");

  // The back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  // Fill count stays within the queue depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCountBits'(QDepth))
    else $error("queue count out of range");

endmodule
